// ===== sv/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset
`define BBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked out of reset
`define BBA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BBA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BBA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/bba_pkg.sv =====
// Package: sizes, codes and the cell control word of the buddy allocator.
`timescale 1ns / 1ps
package bba_pkg;
	localparam int LEVELS      = 16;
	localparam int ADDR_BITS   = 32;
	localparam int STACK_DEPTH = 2;

	localparam int LVL_W  = $clog2(LEVELS);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int SIDX_W = $clog2(STACK_DEPTH);

	// field widths fixed by the interface
	localparam int SIZE_W     = 32;
	localparam int OFF_W      = 32;
	localparam int OUT_LVL_W  = 4;
	localparam int STATUS_W   = 2;
	localparam int MLOG2_W    = 5;
	localparam int TOP_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int EXP_W      = 6;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_GRANT     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_MEM    = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LOG2  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_LEVEL = 2'd1;

	// reset values
	localparam logic [MLOG2_W-1:0] MLOG2_RST = 5'd4;
	localparam logic [TOP_W-1:0]   TOP_RST   = 4'd10;

	// per-cell control word from the sequencer
	typedef struct packed {
		logic init;     // reinitialise the level stack
		logic is_top;   // this level holds the whole region after init
		logic pop;      // drop the top entry
		logic split_in; // push both halves of the block handed down from above
	} bba_cell_ctrl_t;
endpackage

// ===== sv/bba_cell.sv =====
// One level cell: free stack, fit compare and split of the block handed down.
`timescale 1ns / 1ps
module bba_cell import bba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [LVL_W-1:0]     lvl,
	input  logic [MLOG2_W-1:0]   min_log2,
	input  logic [SIZE_W-1:0]    size,
	input  bba_cell_ctrl_t       ctrl,
	input  logic [ADDR_BITS-1:0] down_off,
	output logic [CNT_W-1:0]     count,
	output logic [ADDR_BITS-1:0] top_off,
	output logic                 fits
);
	logic [CNT_W-1:0]     cnt_q;
	logic [ADDR_BITS-1:0] ent_q [STACK_DEPTH];
	logic [EXP_W-1:0]     blk_exp;
	logic [SIZE_W-1:0]    size_m1;
	logic [ADDR_BITS-1:0] half;
	logic [CNT_W-1:0]     cnt_m1;
	logic [CNT_W-1:0]     cnt_p1;

	// block size of this level as a power of two
	assign blk_exp = EXP_W'(min_log2) + EXP_W'(lvl);
	assign size_m1 = size - SIZE_W'(1);
	assign half    = ADDR_BITS'(1) << blk_exp;

	// size <= 2^exp, zero size always fits
	always_comb begin
		if (blk_exp >= EXP_W'(SIZE_W))
			fits = 1'b1;
		else
			fits = (size == '0) || ((size_m1 >> blk_exp) == '0);
	end

	assign cnt_m1  = cnt_q - CNT_W'(1);
	assign cnt_p1  = cnt_q + CNT_W'(1);
	assign count   = cnt_q;
	assign top_off = ent_q[cnt_m1[SIDX_W-1:0]];

	// stack fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.init) begin
			cnt_q <= ctrl.is_top ? CNT_W'(1) : '0;
		end else if (ctrl.pop) begin
			cnt_q <= cnt_m1;
		end else if (ctrl.split_in) begin
			if (cnt_p1 < CNT_W'(STACK_DEPTH))
				cnt_q <= cnt_q + CNT_W'(2);
			else if (cnt_q < CNT_W'(STACK_DEPTH))
				cnt_q <= cnt_p1;
		end
	end

	// stack entries: lower half first, upper half on top; pushes onto a full stack drop
	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			ent_q[0] <= '0;
		end else if (ctrl.split_in) begin
			if (cnt_q < CNT_W'(STACK_DEPTH))
				ent_q[cnt_q[SIDX_W-1:0]] <= down_off;
			if (cnt_p1 < CNT_W'(STACK_DEPTH))
				ent_q[cnt_p1[SIDX_W-1:0]] <= down_off + half;
		end
	end
endmodule

// ===== sv/buddy_block_allocate_core.sv =====
// Top level: buddy block allocator, allocation path, built as a chain of level cells.
// One request is handled at a time. A granted request passes through the states FIT,
// FIND and SRC, one SPLIT state per level split, then POP and DONE, where the result is
// loaded into the output register: the sequencer walks the block down the chain of level
// cells one level per cycle, from the nearest level with a free block to the level that
// fits the request. An oversize request goes from FIND and an out of memory one from SRC
// straight to DONE. The next request can be accepted in the cycle after the load, even
// while that result still waits in the output register. After reset and after every
// write to min_block_log2 or top_level, the free stacks are reinitialised, during which
// no request is accepted. Status 0 is a grant, 1 a request larger than the region, 2 out
// of memory; offset and level read 0 unless granted.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module buddy_block_allocate_core import bba_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SIZE_W-1:0]     req_size,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic [OFF_W-1:0]      block_offset,
	output logic [OUT_LVL_W-1:0]  block_level,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIT   = 3'd1;
	localparam logic [2:0] S_FIND  = 3'd2;
	localparam logic [2:0] S_SRC   = 3'd3;
	localparam logic [2:0] S_SPLIT = 3'd4;
	localparam logic [2:0] S_POP   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]            state_q;
	logic                  init_q;
	logic [MLOG2_W-1:0]    mlog2_q;
	logic [TOP_W-1:0]      top_level_q;
	logic [LVL_W-1:0]      top_eff;
	logic [SIZE_W-1:0]     size_q;
	logic [LEVELS-1:0]     fits_q;
	logic [LEVELS-1:0]     fits_w;
	logic [CNT_W-1:0]      cnt_w     [LEVELS];
	logic [ADDR_BITS-1:0]  top_off_w [LEVELS];
	bba_cell_ctrl_t        ctrl_w    [LEVELS];
	logic [LVL_W-1:0]      want_q;
	logic [LVL_W-1:0]      cur_q;
	logic [LVL_W-1:0]      want_d;
	logic [LVL_W-1:0]      src_d;
	logic                  src_found;
	logic                  too_large;
	logic [STATUS_W-1:0]   res_status_q;
	logic [ADDR_BITS-1:0]  res_off_q;
	logic [LVL_W-1:0]      res_lvl_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [OFF_W-1:0]      out_off_q;
	logic [OUT_LVL_W-1:0]  out_lvl_q;
	logic                  in_acc;
	logic                  cfg_acc;
	logic                  out_load;

	// handshakes
	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !init_q && !cfg_valid;
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// effective top level, saturated to the chain length
	assign top_eff = (32'(top_level_q) > LEVELS - 1) ? LVL_W'(LEVELS - 1)
	                                                 : LVL_W'(top_level_q);

	// configuration registers; a write to either register schedules a stack init
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mlog2_q     <= MLOG2_RST;
			top_level_q <= TOP_RST;
			init_q      <= 1'b1;
		end else begin
			init_q <= 1'b0;
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_MIN_LOG2: begin
						mlog2_q <= cfg_data;
						init_q  <= 1'b1;
					end
					REG_TOP_LEVEL: begin
						top_level_q <= cfg_data[TOP_W-1:0];
						init_q      <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// chain of level cells, each fed by the top entry of the level above
	for (genvar k = 0; k < LEVELS; k++) begin : g_cell
		logic [ADDR_BITS-1:0] down_w;
		logic                 split_w;
		if (k < LEVELS - 1) begin : g_mid
			assign down_w  = top_off_w[k+1];
			assign split_w = (state_q == S_SPLIT) && (cur_q == LVL_W'(k + 1));
		end else begin : g_end
			assign down_w  = '0;
			assign split_w = 1'b0;
		end
		assign ctrl_w[k].init     = init_q;
		assign ctrl_w[k].is_top   = (top_eff == LVL_W'(k));
		assign ctrl_w[k].pop      = ((state_q == S_SPLIT) && (cur_q == LVL_W'(k))) ||
		                            ((state_q == S_POP) && (want_q == LVL_W'(k)) &&
		                             (cnt_w[k] != '0));
		assign ctrl_w[k].split_in = split_w;

		bba_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.lvl      (LVL_W'(k)),
			.min_log2 (mlog2_q),
			.size     (size_q),
			.ctrl     (ctrl_w[k]),
			.down_off (down_w),
			.count    (cnt_w[k]),
			.top_off  (top_off_w[k]),
			.fits     (fits_w[k])
		);
	end

	// smallest fitting level at or below the top
	always_comb begin
		want_d    = top_eff;
		too_large = !fits_q[top_eff];
		for (int k = LEVELS - 1; k >= 0; k--) begin
			if (fits_q[k] && (LVL_W'(k) <= top_eff))
				want_d = LVL_W'(k);
		end
	end

	// nearest level with a free block at or above the wanted one
	always_comb begin
		src_d     = want_q;
		src_found = 1'b0;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			if ((LVL_W'(k) >= want_q) && (LVL_W'(k) <= top_eff) && (cnt_w[k] != '0)) begin
				src_d     = LVL_W'(k);
				src_found = 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (in_acc) state_q <= S_FIT;
				S_FIT:   state_q <= S_FIND;
				S_FIND:  state_q <= too_large ? S_DONE : S_SRC;
				S_SRC: begin
					if (!src_found)
						state_q <= S_DONE;
					else if (src_d == want_q)
						state_q <= S_POP;
					else
						state_q <= S_SPLIT;
				end
				S_SPLIT: if ((cur_q - LVL_W'(1)) == want_q) state_q <= S_POP;
				S_POP:   state_q <= S_DONE;
				S_DONE:  if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request datapath and pending result
	always_ff @(posedge clk) begin
		if (in_acc)
			size_q <= req_size;
		if (state_q == S_FIT)
			fits_q <= fits_w;
		if (state_q == S_FIND) begin
			want_q       <= want_d;
			res_status_q <= too_large ? ST_TOO_LARGE : ST_GRANT;
			res_off_q    <= '0;
			res_lvl_q    <= '0;
		end
		if (state_q == S_SRC) begin
			cur_q <= src_d;
			if (!src_found)
				res_status_q <= ST_NO_MEM;
		end
		if (state_q == S_SPLIT)
			cur_q <= cur_q - LVL_W'(1);
		if (state_q == S_POP) begin
			if (cnt_w[want_q] == '0) begin
				res_status_q <= ST_NO_MEM;
			end else begin
				res_status_q <= ST_GRANT;
				res_off_q    <= top_off_w[want_q];
				res_lvl_q    <= want_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_off_q    <= OFF_W'(res_off_q);
			out_lvl_q    <= OUT_LVL_W'(res_lvl_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign block_offset = out_off_q;
	assign block_level  = out_lvl_q;

	// checks
	`BBA_ASSERT_IMP(a_split_above_want, clk, arst_n, state_q == S_SPLIT, cur_q > want_q)
	`BBA_ASSERT_IMP(a_pop_has_block, clk, arst_n, state_q == S_POP, cnt_w[want_q] != '0)
	`BBA_ASSERT_NXT(a_accept_starts, clk, arst_n, in_acc, state_q == S_FIT)
	`BBA_ASSERT_IMP(a_fail_zero, clk, arst_n, out_valid_q && (out_status_q != ST_GRANT),
		(out_off_q == '0) && (out_lvl_q == '0))
endmodule

// ===== tb/tb_buddy_block_allocate_core.sv =====
// Testbench for the buddy block allocator core: random and directed requests checked by a scoreboard.
`timescale 1ns / 1ps
module tb_buddy_block_allocate_core;
	import bba_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam int PHASES      = 20;
	localparam int PHASE_WORDS = 20;
	localparam int IDLE_PCT    = 26;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// one expected allocation result
	typedef struct {
		logic [STATUS_W-1:0]  st;
		logic [OFF_W-1:0]     off;
		logic [OUT_LVL_W-1:0] lvl;
	} grant_t;

	// Keeps its own copy of the free stacks and registers, predicts each grant
	class alloc_scoreboard;
		logic [MLOG2_W-1:0] min_log2;
		logic [TOP_W-1:0]   top_reg;
		logic [63:0]        stack_off [LEVELS][STACK_DEPTH];
		int                 stack_fill [LEVELS];
		grant_t             pending_grants [$];
		int                 mismatches;

		function int eff_top();
			return (top_reg > LEVELS - 1) ? LEVELS - 1 : int'(top_reg);
		endfunction

		function logic [63:0] blk(int lvl);
			return (64'd1 << min_log2) << lvl;
		endfunction

		function void init_stacks();
			for (int l = 0; l < LEVELS; l++) begin
				stack_fill[l] = 0;
				for (int s = 0; s < STACK_DEPTH; s++)
					stack_off[l][s] = '0;
			end
			stack_fill[eff_top()] = 1;
		endfunction

		function void reset_regs();
			min_log2   = MLOG2_RST;
			top_reg    = TOP_RST;
			mismatches = 0;
			init_stacks();
		endfunction

		// a write to a real register reinitialises the free stacks
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_MIN_LOG2) begin
				min_log2 = data;
				init_stacks();
			end else if (idx == REG_TOP_LEVEL) begin
				top_reg = data[TOP_W-1:0];
				init_stacks();
			end
		endfunction

		// full stack drops the push
		function void push_block(int lvl, logic [63:0] off);
			if (stack_fill[lvl] < STACK_DEPTH) begin
				stack_off[lvl][stack_fill[lvl]] = off & ((64'd1 << ADDR_BITS) - 1);
				stack_fill[lvl]++;
			end
		endfunction

		function logic [63:0] pop_block(int lvl);
			stack_fill[lvl]--;
			return stack_off[lvl][stack_fill[lvl]];
		endfunction

		// work out the grant for an accepted request word
		function void request_taken(logic [SIZE_W-1:0] sz);
			grant_t      g;
			int          top, want, src;
			logic [63:0] off;
			g.st  = ST_GRANT;
			g.off = '0;
			g.lvl = '0;
			top   = eff_top();
			if ({32'b0, sz} > blk(top)) begin
				g.st = ST_TOO_LARGE;
			end else begin
				want = 0;
				while (want < top && blk(want) < {32'b0, sz})
					want++;
				src = want;
				while (src <= top && stack_fill[src] == 0)
					src++;
				if (src > top) begin
					g.st = ST_NO_MEM;
				end else begin
					// split down, upper half stays on top of each stack
					while (src > want) begin
						off = pop_block(src);
						src--;
						push_block(src, off);
						push_block(src, off + blk(src));
					end
					if (stack_fill[want] == 0) begin
						g.st = ST_NO_MEM;
					end else begin
						off   = pop_block(want);
						g.off = off[OFF_W-1:0];
						g.lvl = want[OUT_LVL_W-1:0];
					end
				end
			end
			pending_grants.insert(pending_grants.size(), g);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [OFF_W-1:0] off,
			logic [OUT_LVL_W-1:0] lvl);
			grant_t g;
			if (pending_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: status %0d offset %h level %0d",
						st, off, lvl);
			end else begin
				g = pending_grants.pop_front();
				if (g.st !== st || g.off !== off || g.lvl !== lvl) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: exp status %0d offset %h level %0d, got status %0d offset %h level %0d",
							g.st, g.off, g.lvl, st, off, lvl);
				end
			end
		endfunction

		function int outstanding();
			return pending_grants.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [SIZE_W-1:0]     req_size = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [OFF_W-1:0]      block_offset;
	logic [OUT_LVL_W-1:0]  block_level;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	alloc_scoreboard sb;
	bit              calm = 1'b0;
	int              cycles = 0;

	buddy_block_allocate_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_size     (req_size),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.block_offset (block_offset),
		.block_level  (block_level),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, block_offset, block_level);
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// present one request word, with a random gap in front of it
	task automatic send_req(input logic [SIZE_W-1:0] sz);
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		req_size <= sz;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.request_taken(sz);
	endtask

	// hold off the sender until every result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly sizes that fit a chosen level, some zero, oversize or fully random
	function automatic logic [SIZE_W-1:0] pick_size();
		int          roll, lvl, top;
		logic [63:0] lo, hi, span;
		roll = $urandom_range(0, 99);
		top  = sb.eff_top();
		hi   = sb.blk(top);
		if (roll < 8)
			return '0;
		if (roll < 16)
			return $urandom;
		if (roll < 26) begin
			if (hi >= 64'hFFFF_FFFF)
				return $urandom;
			if (roll < 20)
				return hi[31:0] + 32'd1;
			lo   = hi + 1;
			span = 64'h1_0000_0000 - lo;
			return 32'(lo + ({32'b0, $urandom} % span));
		end
		lvl = $urandom_range(0, $urandom_range(0, top));
		hi  = sb.blk(lvl);
		lo  = (lvl == 0) ? 64'd0 : sb.blk(lvl - 1);
		if (hi > 64'hFFFF_FFFF)
			hi = 64'hFFFF_FFFF;
		if (lo >= hi || roll < 45)
			return hi[31:0];
		return 32'(lo + 1 + ({$urandom, $urandom} % (hi - lo)));
	endfunction

	initial begin
		logic [CFG_DATA_W-1:0] d;
		int                    top_pick;
		sb = new();
		sb.reset_regs();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: tiny, boundary, oversize and whole-region requests
		send_req(32'd0);
		send_req(32'd1);
		send_req(32'd16);
		send_req(32'd17);
		send_req(32'd16384);
		send_req(32'd16385);
		send_req(32'hFFFF_FFFF);
		send_req(32'd8192);
		send_req(32'd4096);
		drain_results();

		// one-byte region
		cfg_write(REG_MIN_LOG2, 5'd0);
		cfg_write(REG_TOP_LEVEL, 5'd0);
		send_req(32'd0);
		send_req(32'd1);
		send_req(32'd2);
		send_req(32'd0);
		drain_results();

		// largest region, offsets wrap past 32 bits
		cfg_write(REG_MIN_LOG2, 5'd20);
		cfg_write(REG_TOP_LEVEL, 5'd15);
		send_req(32'hFFFF_FFFF);
		send_req(32'h8000_0000);
		send_req(32'd0);
		send_req(32'd1);
		drain_results();

		// write to a hole in the map leaves the stacks alone
		cfg_write(REG_UNUSED, 5'h1F);
		send_req(32'd1);
		drain_results();

		// random phases, each under a fresh setting
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			if (p == 0) begin
				cfg_write(REG_MIN_LOG2, 5'd0);
				cfg_write(REG_TOP_LEVEL, 5'd0);
			end else if (p == 1) begin
				cfg_write(REG_MIN_LOG2, 5'd20);
				cfg_write(REG_TOP_LEVEL, 5'd15);
			end else begin
				top_pick = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 7)
					: $urandom_range(0, 15);
				d = {1'($urandom_range(0, 1)), 4'(top_pick)};
				case ($urandom_range(0, 2))
					0: cfg_write(REG_MIN_LOG2, 5'($urandom_range(0, 20)));
					1: cfg_write(REG_TOP_LEVEL, d);
					default: begin
						cfg_write(REG_MIN_LOG2, 5'($urandom_range(0, 20)));
						cfg_write(REG_TOP_LEVEL, d);
					end
				endcase
				if (p == 5)
					cfg_write(REG_UNUSED, 5'($urandom_range(0, 31)));
			end
			calm = (p >= 8 && p <= 10);
			repeat (PHASE_WORDS)
				send_req(pick_size());
		end
		calm = 1'b0;

		drain_results();
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
